// ===== src/vfv_pkg.sv =====
// Package for the voxel face visibility block: shared constants, opcodes,
// FSM state type and the command/status structs passed between units.
// No dependencies.
package vfv_pkg;

  localparam int unsigned GRID_SIDE_DEF = 64;
  localparam int unsigned COORD_W       = 6;
  localparam int unsigned FACE_W        = 6;
  // Width used for grid-bound compares; holds any grid side up to 256.
  localparam int unsigned EXT_W         = 9;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned STEP_W        = 3;

  // Input function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Face bit positions in the mask.
  localparam int unsigned FACE_BACK   = 0;
  localparam int unsigned FACE_FRONT  = 1;
  localparam int unsigned FACE_LEFT   = 2;
  localparam int unsigned FACE_RIGHT  = 3;
  localparam int unsigned FACE_TOP    = 4;
  localparam int unsigned FACE_BOTTOM = 5;

  // Query sequence steps: one row read per step, data used one step later.
  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_XM     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_XP     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_YP     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_YM     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SKIP,
    OP_QUERY
  } vfv_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } vfv_state_e;

  typedef struct packed {
    vfv_op_e             op;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic                solid;
    logic                center_in;
    logic [FACE_W-1:0]   nb_in;
  } vfv_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vfv_qstat_t;

endpackage

// ===== src/vfv_front.sv =====
// Front end: input handshake and item classification (grid bound checks
// for the voxel and its six neighbours). Depends on vfv_pkg.
module vfv_front #(
  parameter int unsigned GRID_SIDE = vfv_pkg::GRID_SIDE_DEF
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [vfv_pkg::COORD_W-1:0] x_i,
  input  logic [vfv_pkg::COORD_W-1:0] y_i,
  input  logic [vfv_pkg::COORD_W-1:0] z_i,
  input  logic                        solid_i,
  input  logic                        clearing_i,
  input  vfv_pkg::vfv_qstat_t         qstat_i,
  output logic                        push_o,
  output vfv_pkg::vfv_cmd_t           cmd_o
);

  localparam logic [vfv_pkg::EXT_W-1:0] GS  = vfv_pkg::EXT_W'(GRID_SIDE);
  localparam logic [vfv_pkg::EXT_W-1:0] ONE = vfv_pkg::EXT_W'(1);

  logic [vfv_pkg::EXT_W-1:0] xe, ye, ze;
  logic xin, yin, zin, xm_in, ym_in, zm_in, xp_in, yp_in, zp_in;

  assign xe = vfv_pkg::EXT_W'(x_i);
  assign ye = vfv_pkg::EXT_W'(y_i);
  assign ze = vfv_pkg::EXT_W'(z_i);

  assign xin   = xe < GS;
  assign yin   = ye < GS;
  assign zin   = ze < GS;
  // c-1 is inside when c > 0 and c-1 < side, i.e. c <= side
  assign xm_in = (x_i != '0) && (xe <= GS);
  assign ym_in = (y_i != '0) && (ye <= GS);
  assign zm_in = (z_i != '0) && (ze <= GS);
  assign xp_in = (xe + ONE) < GS;
  assign yp_in = (ye + ONE) < GS;
  assign zp_in = (ze + ONE) < GS;

  assign in_stall_o = clearing_i || qstat_i.full;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.x         = x_i;
    cmd_o.y         = y_i;
    cmd_o.z         = z_i;
    cmd_o.solid     = solid_i;
    cmd_o.center_in = xin && yin && zin;
    cmd_o.nb_in[vfv_pkg::FACE_BACK]   = xin   && yin   && zm_in;
    cmd_o.nb_in[vfv_pkg::FACE_FRONT]  = xin   && yin   && zp_in;
    cmd_o.nb_in[vfv_pkg::FACE_LEFT]   = xm_in && yin   && zin;
    cmd_o.nb_in[vfv_pkg::FACE_RIGHT]  = xp_in && yin   && zin;
    cmd_o.nb_in[vfv_pkg::FACE_TOP]    = xin   && yp_in && zin;
    cmd_o.nb_in[vfv_pkg::FACE_BOTTOM] = xin   && ym_in && zin;
    if (func_i == vfv_pkg::FUNC_QUERY) begin
      cmd_o.op = vfv_pkg::OP_QUERY;
    end else if (cmd_o.center_in) begin
      cmd_o.op = vfv_pkg::OP_WRITE;
    end else begin
      cmd_o.op = vfv_pkg::OP_SKIP;
    end
  end

endmodule

// ===== src/vfv_queue.sv =====
// Short command FIFO between the front end and the memory sequencer.
// Depends on vfv_pkg.
module vfv_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vfv_pkg::vfv_cmd_t   cmd_i,
  input  logic                pop_i,
  output vfv_pkg::vfv_cmd_t   cmd_o,
  output vfv_pkg::vfv_qstat_t qstat_o
);

  localparam int unsigned QW = $clog2(vfv_pkg::QUEUE_DEPTH);
  localparam logic [QW-1:0] PTR_LAST = QW'(vfv_pkg::QUEUE_DEPTH - 1);
  localparam logic [QW:0]   CNT_FULL = (QW+1)'(vfv_pkg::QUEUE_DEPTH);

  vfv_pkg::vfv_cmd_t store_q [vfv_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign qstat_o.full  = cnt_q == CNT_FULL;
  assign qstat_o.empty = cnt_q == '0;
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign cmd_o   = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + (QW+1)'(1);
      2'b01:   cnt_d = cnt_q - (QW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/vfv_back.sv =====
// Back end: occupancy memory (one z-line per row), clearing pass, query and
// write sequencer, and the result output register. Depends on vfv_pkg.
module vfv_back #(
  parameter int unsigned GRID_SIDE = vfv_pkg::GRID_SIDE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vfv_pkg::vfv_cmd_t          cmd_i,
  input  vfv_pkg::vfv_qstat_t        qstat_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       filled_o,
  output logic [vfv_pkg::FACE_W-1:0] face_mask_o
);

  localparam int unsigned AW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned RW   = 1 << AW;
  localparam int unsigned RA   = 2 * AW;
  localparam int unsigned ROWS = 1 << RA;
  localparam logic [AW-1:0] ONE = AW'(1);

  vfv_pkg::vfv_state_e state_q, state_d;
  vfv_pkg::vfv_cmd_t   cmd_q, cmd_d;
  logic [vfv_pkg::STEP_W-1:0] step_q, step_d;
  logic [RA-1:0]       clr_q, clr_d;

  logic                      res_filled_q, res_filled_d;
  logic [vfv_pkg::FACE_W-1:0] res_mask_q, res_mask_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_filled_q, out_filled_d;
  logic [vfv_pkg::FACE_W-1:0] out_mask_q, out_mask_d;

  logic [RW-1:0] mem [ROWS];
  logic [RW-1:0] rd_q;
  logic [RA-1:0] mem_addr;
  logic          mem_re, mem_bwe, mem_clr;

  logic [AW-1:0] xc, yc, zc, xm, xp, ym, yp, zm, zp;
  logic          out_take;

  assign xc = AW'(cmd_q.x);
  assign yc = AW'(cmd_q.y);
  assign zc = AW'(cmd_q.z);
  assign xm = xc - ONE;
  assign xp = xc + ONE;
  assign ym = yc - ONE;
  assign yp = yc + ONE;
  assign zm = zc - ONE;
  assign zp = zc + ONE;

  assign out_take    = out_valid_q && !out_stall_i;
  assign clearing_o  = state_q == vfv_pkg::ST_CLEAR;
  assign out_valid_o = out_valid_q;
  assign filled_o    = out_filled_q;
  assign face_mask_o = out_mask_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    step_d       = step_q;
    clr_d        = clr_q;
    res_filled_d = res_filled_q;
    res_mask_d   = res_mask_q;
    out_valid_d  = out_valid_q && !out_take;
    out_filled_d = out_filled_q;
    out_mask_d   = out_mask_q;
    pop_o        = 1'b0;
    mem_re       = 1'b0;
    mem_bwe      = 1'b0;
    mem_clr      = 1'b0;
    mem_addr     = {xc, yc};

    unique case (state_q)
      vfv_pkg::ST_CLEAR: begin
        mem_clr  = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + RA'(1);
        if (clr_q == '1) begin
          state_d = vfv_pkg::ST_IDLE;
        end
      end
      vfv_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o      = 1'b1;
          cmd_d      = cmd_i;
          step_d     = vfv_pkg::STEP_CENTER;
          res_mask_d = '0;
          state_d    = vfv_pkg::ST_RUN;
        end
      end
      vfv_pkg::ST_RUN: begin
        step_d = step_q + vfv_pkg::STEP_W'(1);
        unique case (cmd_q.op)
          vfv_pkg::OP_WRITE: begin
            mem_bwe      = 1'b1;
            res_filled_d = cmd_q.solid;
            res_mask_d   = '0;
            state_d      = vfv_pkg::ST_DONE;
          end
          vfv_pkg::OP_QUERY: begin
            // rd_q holds the row read in the previous step
            case (step_q)
              vfv_pkg::STEP_CENTER: begin
                mem_re   = 1'b1;
                mem_addr = {xc, yc};
              end
              vfv_pkg::STEP_XM: begin
                mem_re       = 1'b1;
                mem_addr     = {xm, yc};
                res_filled_d = cmd_q.center_in && rd_q[zc];
                res_mask_d[vfv_pkg::FACE_BACK] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_BACK] && rd_q[zm]);
                res_mask_d[vfv_pkg::FACE_FRONT] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_FRONT] && rd_q[zp]);
              end
              vfv_pkg::STEP_XP: begin
                mem_re   = 1'b1;
                mem_addr = {xp, yc};
                res_mask_d[vfv_pkg::FACE_LEFT] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_LEFT] && rd_q[zc]);
              end
              vfv_pkg::STEP_YP: begin
                mem_re   = 1'b1;
                mem_addr = {xc, yp};
                res_mask_d[vfv_pkg::FACE_RIGHT] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_RIGHT] && rd_q[zc]);
              end
              vfv_pkg::STEP_YM: begin
                mem_re   = 1'b1;
                mem_addr = {xc, ym};
                res_mask_d[vfv_pkg::FACE_TOP] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_TOP] && rd_q[zc]);
              end
              vfv_pkg::STEP_LAST: begin
                res_mask_d[vfv_pkg::FACE_BOTTOM] =
                  !(cmd_q.nb_in[vfv_pkg::FACE_BOTTOM] && rd_q[zc]);
                state_d = vfv_pkg::ST_DONE;
              end
              default: begin
                state_d = vfv_pkg::ST_DONE;
              end
            endcase
          end
          default: begin
            // write outside the grid: no store update
            res_filled_d = 1'b0;
            res_mask_d   = '0;
            state_d      = vfv_pkg::ST_DONE;
          end
        endcase
      end
      vfv_pkg::ST_DONE: begin
        if (!out_valid_q || out_take) begin
          out_valid_d  = 1'b1;
          out_filled_d = res_filled_q;
          out_mask_d   = res_mask_q;
          state_d      = vfv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vfv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfv_pkg::ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_filled_q <= res_filled_d;
    res_mask_q   <= res_mask_d;
    out_filled_q <= out_filled_d;
    out_mask_q   <= out_mask_d;
  end

  // Single-port occupancy store: clear a row, write one bit, or read a row.
  always_ff @(posedge clk_i) begin
    if (mem_clr) begin
      mem[mem_addr] <= '0;
    end else if (mem_bwe) begin
      mem[mem_addr][zc] <= cmd_q.solid;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

endmodule

// ===== src/voxel_face_visibility_mask.sv =====
// Top level of the voxel face visibility block: front end, command queue
// and memory sequencer. Depends on vfv_pkg, vfv_front, vfv_queue, vfv_back.
//
// Holds a GRID_SIDE^3 one-bit occupancy grid stored as one z-line per memory
// row in a single-port memory. After reset a clearing pass zeroes the store,
// one row per cycle, over all 2^(2*ceil(log2(GRID_SIDE))) rows (4096 at the
// default side of 64); input stays stalled during that pass. A write
// transaction (func 0) returns the stored bit with a zero mask; a query
// (func 1) is paced by the five row reads of the single memory port (the
// center row gives z-1, z and z+1; x-1, x+1, y+1, y-1 each need their own
// row). A two-entry queue lets the front accept new transactions while the
// sequencer works and a result waits in the output register.
module voxel_face_visibility_mask #(
  parameter int unsigned GRID_SIDE = vfv_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [vfv_pkg::COORD_W-1:0] x_i,
  input  logic [vfv_pkg::COORD_W-1:0] y_i,
  input  logic [vfv_pkg::COORD_W-1:0] z_i,
  input  logic                        solid_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        filled_o,
  output logic [vfv_pkg::FACE_W-1:0]  face_mask_o
);

  vfv_pkg::vfv_cmd_t   push_cmd, pop_cmd;
  vfv_pkg::vfv_qstat_t qstat;
  logic                push, pop, clearing;

  vfv_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .x_i        (x_i),
    .y_i        (y_i),
    .z_i        (z_i),
    .solid_i    (solid_i),
    .clearing_i (clearing),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  vfv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .qstat_o (qstat)
  );

  vfv_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filled_o    (filled_o),
    .face_mask_o (face_mask_o)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("transaction accepted during clearing pass");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o)
    else $error("result presented during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full command queue");

  a_queue_empty_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing) |-> qstat.empty)
    else $error("command queue not empty when clearing ends");
`endif

endmodule

// ===== sim/tb_voxel_face_visibility_mask.sv =====
// Self-checking testbench for voxel_face_visibility_mask: directed table, then random
// write/query traffic clustered so that neighbors are often filled, with random idling.
// Depends on vfv_pkg and the RTL of voxel_face_visibility_mask.
module tb_voxel_face_visibility_mask;
  timeunit 1ns;
  timeprecision 1ps;

  import vfv_pkg::*;

  localparam int SIDE          = GRID_SIDE_DEF;
  localparam int GRID_VOXELS   = SIDE * SIDE * SIDE;
  localparam int RANDOM_ITEMS  = 1126;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECTED_COUNT = 24;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               solid;
    logic               fixed_exp;
    logic               filled;
    logic [FACE_W-1:0]  mask;
  } probe_row_t;

  typedef struct packed {
    logic              filled;
    logic [FACE_W-1:0] mask;
  } face_result_t;

  // fields: func, x, y, z, solid, expectation typed in, filled, face mask
  localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty grid after reset, corners, solid ignored on a query
    '{FUNC_QUERY, 6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 6'h3F},
    '{FUNC_QUERY, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 6'h3F},
    '{FUNC_WRITE, 6'd0,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 6'h00},
    // filled center with only empty or outside neighbors
    '{FUNC_QUERY, 6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 1'b1, 6'h3F},
    '{FUNC_WRITE, 6'd0,  6'd0,  6'd1,  1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd1,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd0,  6'd1,  6'd0,  1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_QUERY, 6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 6'h00},
    '{FUNC_QUERY, 6'd63, 6'd63, 6'd62, 1'b0, 1'b0, 1'b0, 6'h00},
    // enclose an empty voxel on all six faces
    '{FUNC_WRITE, 6'd32, 6'd32, 6'd31, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd32, 6'd32, 6'd33, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd31, 6'd32, 6'd32, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd33, 6'd32, 6'd32, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd32, 6'd33, 6'd32, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_WRITE, 6'd32, 6'd31, 6'd32, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_QUERY, 6'd32, 6'd32, 6'd32, 1'b0, 1'b0, 1'b0, 6'h00},
    '{FUNC_WRITE, 6'd32, 6'd32, 6'd32, 1'b1, 1'b1, 1'b1, 6'h00},
    '{FUNC_QUERY, 6'd32, 6'd32, 6'd32, 1'b1, 1'b0, 1'b0, 6'h00},
    // clearing writes
    '{FUNC_WRITE, 6'd32, 6'd33, 6'd32, 1'b0, 1'b1, 1'b0, 6'h00},
    '{FUNC_QUERY, 6'd32, 6'd32, 6'd32, 1'b0, 1'b0, 1'b0, 6'h00},
    '{FUNC_WRITE, 6'd63, 6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 6'h00},
    '{FUNC_QUERY, 6'd63, 6'd63, 6'd62, 1'b0, 1'b0, 1'b0, 6'h00},
    '{FUNC_QUERY, 6'd63, 6'd0,  6'd63, 1'b1, 1'b1, 1'b0, 6'h3F}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_func = FUNC_WRITE;
  logic [COORD_W-1:0] in_x = '0;
  logic [COORD_W-1:0] in_y = '0;
  logic [COORD_W-1:0] in_z = '0;
  logic               in_solid = 1'b0;
  logic               out_stall = 1'b1;
  logic               row_fixed = 1'b0;
  face_result_t       row_result = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic               filled_o;
  logic [FACE_W-1:0]  face_mask_o;

  bit                 voxel_grid [GRID_VOXELS];
  face_result_t       expected_faces [$];
  int                 mismatch_cnt = 0;
  int                 cycle_cnt = 0;
  bit                 hold_request = 1'b0;
  int                 cluster_base [3];

  voxel_face_visibility_mask u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .func_i     (in_func),
    .x_i        (in_x),
    .y_i        (in_y),
    .z_i        (in_z),
    .solid_i    (in_solid),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .filled_o   (filled_o),
    .face_mask_o(face_mask_o)
  );

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Neighbors outside the grid read as empty.
  function automatic bit voxel_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE) begin
      return 1'b0;
    end
    return voxel_grid[(x * SIDE + y) * SIDE + z];
  endfunction

  function automatic face_result_t predict_faces(logic func, logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y,
                                                 logic [COORD_W-1:0] z, logic solid);
    face_result_t r;
    int ix;
    int iy;
    int iz;
    ix = int'(x);
    iy = int'(y);
    iz = int'(z);
    r = '0;
    if (func == FUNC_WRITE) begin
      if (ix < SIDE && iy < SIDE && iz < SIDE) begin
        voxel_grid[(ix * SIDE + iy) * SIDE + iz] = solid;
        r.filled = solid;
      end
    end else begin
      r.filled = voxel_at(ix, iy, iz);
      r.mask[FACE_BACK]   = !voxel_at(ix, iy, iz - 1);
      r.mask[FACE_FRONT]  = !voxel_at(ix, iy, iz + 1);
      r.mask[FACE_LEFT]   = !voxel_at(ix - 1, iy, iz);
      r.mask[FACE_RIGHT]  = !voxel_at(ix + 1, iy, iz);
      r.mask[FACE_TOP]    = !voxel_at(ix, iy + 1, iz);
      r.mask[FACE_BOTTOM] = !voxel_at(ix, iy - 1, iz);
    end
    return r;
  endfunction

  // Mostly a small cube so that neighbors get filled; some grid edges, some anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(int axis);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return COORD_W'(cluster_base[axis] + $urandom_range(0, 3));
    end else if (r < 8) begin
      return ($urandom_range(0, 1) != 0) ? COORD_W'(SIDE - 1) : '0;
    end
    return COORD_W'($urandom_range(0, SIDE - 1));
  endfunction

  task automatic offer_item(probe_row_t row);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    in_func    <= row.func;
    in_x       <= row.x;
    in_y       <= row.y;
    in_z       <= row.z;
    in_solid   <= row.solid;
    row_fixed  <= row.fixed_exp;
    row_result <= '{filled: row.filled, mask: row.mask};
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // Prediction on input transactions, checking on output transactions.
  always @(posedge clk_i) begin
    face_result_t predicted;
    face_result_t oldest;
    if (in_valid && !in_stall_o) begin
      predicted = predict_faces(in_func, in_x, in_y, in_z, in_solid);
      expected_faces = {expected_faces, (row_fixed ? row_result : predicted)};
    end
    if (out_valid_o && !out_stall) begin
      if (expected_faces.size() == 0) begin
        $display("%0t unexpected result: filled %0d face_mask %02h", $time, filled_o,
                 face_mask_o);
        mismatch_cnt++;
      end else begin
        oldest = expected_faces.pop_front();
        if (filled_o !== oldest.filled) begin
          $display("%0t filled mismatch: expected %0d actual %0d", $time, oldest.filled,
                   filled_o);
          mismatch_cnt++;
        end
        if (face_mask_o !== oldest.mask) begin
          $display("%0t face_mask mismatch: expected %02h actual %02h", $time, oldest.mask,
                   face_mask_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Receiver: runs of different stall patterns, plus one long hold-off.
  initial begin
    int mode;
    int run_len;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(10, 60);
      for (int i = 0; i < run_len; i++) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (i % 4) != 0;
          default: out_stall <= $urandom_range(0, 9) < 2;
        endcase
      end
      if (hold_request && !hold_done) begin
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          @(negedge clk_i);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end
    end
  end

  initial begin
    probe_row_t row;
    int burst_left;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      offer_item(DIRECTED_ROWS[i]);
      if ($urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 5));
      end
    end
    idle_cycles(1);
    while (expected_faces.size() != 0) @(posedge clk_i);

    hold_request = 1'b1;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        for (int a = 0; a < 3; a++) begin
          case ($urandom_range(0, 2))
            0: cluster_base[a] = 0;
            1: cluster_base[a] = SIDE - 4;
            default: cluster_base[a] = $urandom_range(0, SIDE - 4);
          endcase
        end
      end
      // sender waits for the block to drain completely once
      if (n == RANDOM_ITEMS / 2) begin
        idle_cycles(1);
        while (expected_faces.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (n < 300 || n >= 400) begin
          idle_cycles($urandom_range(0, 12));
        end
      end
      row.func      = ($urandom_range(0, 99) < 50) ? FUNC_QUERY : FUNC_WRITE;
      row.x         = pick_coord(0);
      row.y         = pick_coord(1);
      row.z         = pick_coord(2);
      row.solid     = (row.func == FUNC_WRITE) ? ($urandom_range(0, 99) < 70)
                                               : 1'($urandom_range(0, 1));
      row.fixed_exp = 1'b0;
      row.filled    = 1'b0;
      row.mask      = '0;
      offer_item(row);
      burst_left--;
    end
    idle_cycles(1);

    while (expected_faces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
